// File: rtl/core/ida_pkg.sv
`default_nettype none

package ida_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int DIGIT_SLOTS = (VALUE_WIDTH * 301) / 1000 + 2;
    localparam int DIGIT_IDX_W = $clog2(DIGIT_SLOTS);
    localparam int STEP_W      = $clog2(VALUE_WIDTH);

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam logic CMD_UNSIGNED = 1'b0;
    localparam logic CMD_SIGNED   = 1'b1;

    typedef struct packed {
        logic [31:0] value;
        logic        command;
    } t_in;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_COUNT,
        ST_SIGN,
        ST_DIGIT,
        ST_NEWLINE
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
        logic count;
        logic emit_sign;
        logic emit_digit;
        logic emit_nl;
    } t_dp_cmd;

    typedef struct packed {
        logic neg;
        logic digit_last;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: rtl/core/ida_ctrl.sv
`default_nettype none

module ida_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  ida_pkg::t_dp_stat   i_stat,
    output ida_pkg::t_dp_cmd    o_cmd,
    output logic                o_busy
);
    import ida_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              step_done;

    assign step_done = (r_step == STEP_W'(VALUE_WIDTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (i_start) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_step = r_step + 1'b1;
                if (step_done) begin
                    n_state = ST_COUNT;
                end
            end
            ST_COUNT: begin
                n_state = i_stat.neg ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN: begin
                n_state = ST_DIGIT;
            end
            ST_DIGIT: begin
                if (i_stat.digit_last) begin
                    n_state = ST_NEWLINE;
                end
            end
            ST_NEWLINE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            ST_CONV:    o_cmd.shift      = 1'b1;
            ST_COUNT:   o_cmd.count      = 1'b1;
            ST_SIGN:    o_cmd.emit_sign  = 1'b1;
            ST_DIGIT:   o_cmd.emit_digit = 1'b1;
            ST_NEWLINE: o_cmd.emit_nl    = 1'b1;
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/ida_datapath.sv
`default_nettype none

module ida_datapath (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ida_pkg::t_in        i_in,
    input  ida_pkg::t_dp_cmd    i_cmd,
    output ida_pkg::t_dp_stat   o_stat,
    output ida_pkg::t_out       o_out,
    output logic                o_valid
);
    import ida_pkg::*;

    logic [VALUE_WIDTH-1:0] r_mag;
    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] load_mag;
    logic                   load_neg;
    logic                   r_neg;
    logic [3:0]             r_bcd [DIGIT_SLOTS];
    logic [3:0]             adj   [DIGIT_SLOTS];
    logic [3:0]             n_bcd [DIGIT_SLOTS];
    logic [DIGIT_IDX_W-1:0] r_idx;
    logic [DIGIT_IDX_W-1:0] top_idx;
    t_out                   r_out;
    logic                   r_valid;

    assign raw      = i_in.value[VALUE_WIDTH-1:0];
    assign load_neg = (i_in.command == CMD_SIGNED) && raw[VALUE_WIDTH-1];
    assign load_mag = load_neg ? (~raw + 1'b1) : raw;

    always_comb begin
        for (int i = 0; i < DIGIT_SLOTS; i++) begin
            adj[i] = (r_bcd[i] >= 4'd5) ? (r_bcd[i] + 4'd3) : r_bcd[i];
        end
        n_bcd[0] = {adj[0][2:0], r_mag[VALUE_WIDTH-1]};
        for (int i = 1; i < DIGIT_SLOTS; i++) begin
            n_bcd[i] = {adj[i][2:0], adj[i-1][3]};
        end
    end

    always_comb begin
        top_idx = '0;
        for (int i = 0; i < DIGIT_SLOTS; i++) begin
            if (r_bcd[i] != 4'd0) begin
                top_idx = DIGIT_IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag <= load_mag;
            r_neg <= load_neg;
            for (int i = 0; i < DIGIT_SLOTS; i++) begin
                r_bcd[i] <= 4'd0;
            end
        end else if (i_cmd.shift) begin
            r_mag <= {r_mag[VALUE_WIDTH-2:0], 1'b0};
            for (int i = 0; i < DIGIT_SLOTS; i++) begin
                r_bcd[i] <= n_bcd[i];
            end
        end
        if (i_cmd.count) begin
            r_idx <= top_idx;
        end else if (i_cmd.emit_digit) begin
            r_idx <= r_idx - 1'b1;
        end
        if (i_cmd.emit_sign) begin
            r_out.char_byte <= CHAR_MINUS;
            r_out.last      <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_out.char_byte <= CHAR_ZERO + {4'd0, r_bcd[r_idx]};
            r_out.last      <= 1'b0;
        end else if (i_cmd.emit_nl) begin
            r_out.char_byte <= CHAR_NEWLINE;
            r_out.last      <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit_sign | i_cmd.emit_digit | i_cmd.emit_nl;
        end
    end

    assign o_stat.neg        = r_neg;
    assign o_stat.digit_last = (r_idx == '0);
    assign o_out             = r_out;
    assign o_valid           = r_valid;

endmodule

`default_nettype wire

// File: rtl/core/integer_to_decimal_ascii.sv
// Channel   Handshake          Payload
// input     i_start / o_busy   i_in  (value, command)
// result    o_valid strobe     o_out (char_byte, last)
//
// An item is taken when i_start is high and o_busy is low. The block is busy
// through 32 double-dabble shift steps, one digit-count step, then one emit
// step per character of '-', digits and newline.
// Each result appears in the cycle after its emit step and holds for one cycle.
// Reset returns the controller to idle and drops any run in progress.
// The receiver cannot stall; results are never held back.
`default_nettype none

module integer_to_decimal_ascii (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_start,
    input  ida_pkg::t_in    i_in,
    output logic            o_busy,
    output ida_pkg::t_out   o_out,
    output logic            o_valid
);
    import ida_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ida_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    ida_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_out   (o_out),
        .o_valid (o_valid)
    );

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted transfer did not raise busy");

    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy))
        else $error("result strobe without a run in progress");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.last) |-> (!o_busy && o_out.char_byte == CHAR_NEWLINE))
        else $error("last character is not a newline at end of run");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out.last && o_out.char_byte != CHAR_MINUS) |->
        (o_out.char_byte >= CHAR_ZERO && o_out.char_byte <= CHAR_ZERO + 8'd9))
        else $error("digit character out of range");

endmodule

`default_nettype wire

// File: sim/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ida_pkg::*;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_in  i_in    = '0;
    logic o_busy;
    t_out o_out;
    logic o_valid;

    t_out        expected_chars[$];
    int unsigned mismatches = 0;

    integer_to_decimal_ascii DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_in    (i_in),
        .o_busy  (o_busy),
        .o_out   (o_out),
        .o_valid (o_valid)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic void push_decimal_text(input t_in item);
        logic [31:0] mag;
        logic [3:0]  digits[12];
        logic        neg;
        int          n;
        t_out        ch;
        neg = (item.command == CMD_SIGNED) && item.value[31];
        mag = neg ? (~item.value + 32'd1) : item.value;
        n   = 0;
        do begin
            digits[n] = 4'(mag % 32'd10);
            n++;
            mag = mag / 32'd10;
        end while (mag != 32'd0);
        if (neg) begin
            ch.char_byte = CHAR_MINUS;
            ch.last      = 1'b0;
            expected_chars.push_back(ch);
        end
        for (int i = n - 1; i >= 0; i--) begin
            ch.char_byte = CHAR_ZERO + 8'(digits[i]);
            ch.last      = 1'b0;
            expected_chars.push_back(ch);
        end
        ch.char_byte = CHAR_NEWLINE;
        ch.last      = 1'b1;
        expected_chars.push_back(ch);
    endfunction

    // hold start high through the transfer; the caller lowers it
    task automatic send_number(input logic [31:0] value, input logic command);
        t_in item;
        item.value   = value;
        item.command = command;
        i_start <= 1'b1;
        i_in    <= item;
        do @(posedge i_clk); while (o_busy);
        push_decimal_text(item);
    endtask

    task automatic idle_burst(input bit after_done);
        int unsigned gap;
        gap = $urandom_range(1, 14);
        i_start <= 1'b0;
        if (after_done) begin
            do @(posedge i_clk); while (o_busy);
        end
        repeat (gap) begin
            i_in <= {$urandom, 1'($urandom)};
            @(posedge i_clk);
        end
    endtask

    task automatic drain_expected();
        i_start <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] random_value();
        logic [31:0] p;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom >> $urandom_range(0, 31);
            2: begin
                p = 32'd1;
                repeat ($urandom_range(0, 9)) p = p * 32'd10;
                return p + 32'($urandom_range(0, 2)) - 32'd1;
            end
            default: return -($urandom >> $urandom_range(0, 31));
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                          o_out.char_byte, o_out.last));
            end else begin
                want = expected_chars.pop_front();
                if (o_out.char_byte !== want.char_byte)
                    report_mismatch($sformatf("char_byte 0x%02h, want 0x%02h",
                                              o_out.char_byte, want.char_byte));
                if (o_out.last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b (char 0x%02h)",
                                              o_out.last, want.last, want.char_byte));
            end
        end
    end

    task automatic test_extremes();
        send_number(32'd0, CMD_UNSIGNED);
        send_number(32'd0, CMD_SIGNED);
        send_number(32'hFFFF_FFFF, CMD_UNSIGNED);
        send_number(32'hFFFF_FFFF, CMD_SIGNED);
        send_number(32'h8000_0000, CMD_UNSIGNED);
        send_number(32'h8000_0000, CMD_SIGNED);
        send_number(32'h7FFF_FFFF, CMD_UNSIGNED);
        send_number(32'h7FFF_FFFF, CMD_SIGNED);
        send_number(32'd1, CMD_UNSIGNED);
        send_number(32'd9, CMD_SIGNED);
        send_number(32'd10, CMD_UNSIGNED);
        send_number(32'd99, CMD_UNSIGNED);
        send_number(32'd100, CMD_SIGNED);
        send_number(32'd999_999_999, CMD_UNSIGNED);
        send_number(32'd1_000_000_000, CMD_UNSIGNED);
        send_number(-32'd10, CMD_SIGNED);
        send_number(32'hAAAA_AAAA, CMD_UNSIGNED);
        send_number(32'h5555_5555, CMD_SIGNED);
        send_number(32'hAAAA_AAAA, CMD_SIGNED);
    endtask

    task automatic test_random_gaps(input int count);
        repeat (count) begin
            if ($urandom_range(0, 9) < 4)
                idle_burst($urandom_range(0, 1));
            send_number(random_value(), 1'($urandom));
        end
    endtask

    task automatic test_pause_until_drained();
        send_number(random_value(), CMD_SIGNED);
        drain_expected();
        send_number(random_value(), CMD_UNSIGNED);
    endtask

    task automatic test_back_to_back(input int count);
        repeat (count) send_number(random_value(), 1'($urandom));
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_random_gaps(80);
        test_pause_until_drained();
        test_random_gaps(80);
        test_back_to_back(40);

        drain_expected();
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
